/* hw/rtl/ialu_pkg.sv */
// Package: operation codes and transfer payload types of the integer ALU core.
package ialu_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 6;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_SET = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLR = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TGL = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_GET = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [POS_W-1:0]  bit_pos;
  } ialu_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              div_zero;
  } ialu_out_t;

endpackage

/* hw/rtl/integer_alu_mul_div_core.sv */
// Top level: unsigned ALU with bit ops, add/sub, shift-add multiply, restoring divide.
//
//  channel | ports                              | payload
//  --------+------------------------------------+---------------------------
//  input   | in_valid, in_stall, in_data        | func, operand_a/b, bit_pos
//  result  | out_valid, out_stall, out_data     | result, div_zero
//
// Bit ops, add, subtract and divide by zero are computed at the input transfer, then
// loaded into the output register. Multiply and divide take one step per operand bit
// through the single shared WORD_BITS+1 bit adder/subtractor before that load.
// in_stall is high from the input transfer until the result is loaded into the
// output register; a new item is taken while that result waits on out_stall.
// rst_n is synchronous, active low, and clears the sequencer and output valid.
module integer_alu_mul_div_core #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ialu_pkg::ialu_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ialu_pkg::ialu_out_t out_data
);
  import ialu_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned CW = $clog2(WORD_BITS);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          is_div_r, is_div_nxt;
  logic          dz_r, dz_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic          out_valid_r, out_valid_nxt;
  ialu_out_t     out_data_r, out_data_nxt;

  logic          in_xfer;
  logic          out_free;
  logic [W-1:0]  op_a, op_b, bit_m;
  logic [W:0]    unit_x, unit_y, unit_sum;
  logic          unit_sub;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Operands cut to the word; position one-hot (zero when beyond the word)
  assign op_a  = in_data.operand_a[W-1:0];
  assign op_b  = in_data.operand_b[W-1:0];
  assign bit_m = W'(1) << in_data.bit_pos;

  // Shared adder/subtractor operand select
  always_comb begin
    unit_x   = {1'b0, op_a};
    unit_y   = {1'b0, op_b};
    unit_sub = (in_data.func == FUNC_SUB);
    if (state_r == ST_CALC) begin
      if (is_div_r) begin
        unit_x   = {rem_r, a_r[W-1]};
        unit_y   = {1'b0, b_r};
        unit_sub = 1'b1;
      end else begin
        unit_x   = {1'b0, res_r};
        unit_y   = {1'b0, (b_r[0] ? a_r : '0)};
        unit_sub = 1'b0;
      end
    end
  end

  assign unit_sum = unit_x + (unit_sub ? ~unit_y : unit_y) + (W+1)'(unit_sub);

  // Sequencer and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    is_div_nxt    = is_div_r;
    dz_nxt        = dz_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          a_nxt      = op_a;
          b_nxt      = op_b;
          rem_nxt    = '0;
          dz_nxt     = 1'b0;
          cnt_nxt    = CW'(W - 1);
          is_div_nxt = (in_data.func == FUNC_DIV);
          state_nxt  = ST_DONE;
          case (in_data.func)
            FUNC_SET: res_nxt = op_a | bit_m;
            FUNC_CLR: res_nxt = op_a & ~bit_m;
            FUNC_TGL: res_nxt = op_a ^ bit_m;
            FUNC_GET: res_nxt = W'(|(op_a & bit_m));
            FUNC_ADD: res_nxt = unit_sum[W-1:0];
            FUNC_SUB: res_nxt = unit_sum[W-1:0];
            FUNC_MUL: begin
              res_nxt   = '0;
              state_nxt = ST_CALC;
            end
            FUNC_DIV: begin
              res_nxt = '0;
              if (op_b == '0) begin
                dz_nxt = 1'b1;
              end else begin
                state_nxt = ST_CALC;
              end
            end
            default: res_nxt = '0;
          endcase
        end
      end
      ST_CALC: begin
        a_nxt = a_r << 1;
        if (is_div_r) begin
          // Restoring step: keep the difference when no borrow
          if (!unit_sum[W]) begin
            rem_nxt = unit_sum[W-1:0];
          end else begin
            rem_nxt = unit_x[W-1:0];
          end
          res_nxt = {res_r[W-2:0], !unit_sum[W]};
        end else begin
          // Shift-and-add step
          res_nxt = unit_sum[W-1:0];
          b_nxt   = b_r >> 1;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.result   = DATA_W'(res_r);
          out_data_nxt.div_zero = dz_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    is_div_r   <= is_div_nxt;
    dz_r       <= dz_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    res_r      <= res_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken while a previous item is in flight");

  a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.div_zero) |-> (out_data_r.result == '0))
    else $error("divide by zero with nonzero result");

  a_calc_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && cnt_r == '0) |=> (state_r == ST_DONE))
    else $error("iteration count overran");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=> (state_r == ST_DONE))
    else $error("result dropped while output register busy");

endmodule

/* tb/tb_top.sv */
// Testbench: integer ALU core, checked transfer by transfer against a built-in predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ialu_pkg::*;

  localparam int unsigned WB         = 64;
  localparam int          RAND_ITEMS = 1950;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          TAIL_WAIT  = 80;

  typedef struct {
    ialu_in_t data;
    bit       drain;  // hold this item until every expected result is back
  } queued_op_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  ialu_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ialu_out_t out_data;

  queued_op_t op_queue[$];
  ialu_out_t  pending_results[$];

  bit in_took     = 1'b0;
  int gap_left    = 0;
  int stall_left  = 0;
  int sent_cnt    = 0;
  int cycle_cnt   = 0;
  int idle_cycles = 0;
  int errors      = 0;
  int dz_cnt      = 0;
  int op_count[8];

  integer_alu_mul_div_core #(.WORD_BITS(WB)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Low WB bits of the product, one partial sum per multiplier bit
  function automatic logic [63:0] shift_add_product(logic [63:0] a, logic [63:0] b,
                                                    logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = 0; i < WB; i++) begin
      if (b[0]) acc = (acc + a) & m;
      a = (a << 1) & m;
      b = b >> 1;
    end
    return acc;
  endfunction

  // Quotient by restoring division, MSB first; over catches the shifted-out bit
  function automatic logic [63:0] restoring_quotient(logic [63:0] a, logic [63:0] b,
                                                     logic [63:0] m);
    logic [63:0] quo;
    logic [63:0] rem;
    logic        over;
    quo = '0;
    rem = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      over = rem[WB-1];
      rem  = ((rem << 1) | ((a >> i) & 64'd1)) & m;
      if (over || rem >= b) begin
        rem    = (rem - b) & m;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic ialu_out_t compute_alu_result(ialu_in_t op);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] bitm;
    ialu_out_t   r;
    m    = {64{1'b1}} >> (64 - WB);
    a    = op.operand_a & m;
    b    = op.operand_b & m;
    bitm = (op.bit_pos < WB) ? (64'd1 << op.bit_pos) : 64'd0;
    r    = '0;
    case (op.func)
      FUNC_SET: r.result = a | bitm;
      FUNC_CLR: r.result = a & ~bitm;
      FUNC_TGL: r.result = a ^ bitm;
      FUNC_GET: r.result = ((a & bitm) != 0) ? 64'd1 : 64'd0;
      FUNC_ADD: r.result = a + b;
      FUNC_SUB: r.result = a - b;
      FUNC_MUL: r.result = shift_add_product(a, b, m);
      default: begin
        if (b == 0) r.div_zero = 1'b1;
        else        r.result   = restoring_quotient(a, b, m);
      end
    endcase
    r.result = r.result & m;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Operand shapes: edges, single bits and their inverses, small values, shifted and plain random words
  function automatic logic [63:0] shaped_operand();
    int k;
    k = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return {64{1'b1}};
      2:       return 64'd1 << k;
      3:       return 64'($urandom_range(0, 255));
      4:       return ~(64'd1 << k);
      5:       return rand64() >> k;
      default: return rand64();
    endcase
  endfunction

  // Sender gap: mostly none or short, now and then long; bursts with no gaps
  function automatic int pick_gap();
    int r;
    if ((sent_cnt / 128) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(30, 150);
  endfunction

  function automatic int pick_stall();
    int r;
    if ((cycle_cnt / 3000) % 5 == 4) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  task automatic queue_op(logic [FUNC_W-1:0] f, logic [63:0] a, logic [63:0] b,
                          logic [POS_W-1:0] pos, bit drain);
    queued_op_t q;
    q.data.func      = f;
    q.data.operand_a = a;
    q.data.operand_b = b;
    q.data.bit_pos   = pos;
    q.drain          = drain;
    op_queue.push_back(q);
  endtask

  // Input driver: new item on the falling edge after the previous transfer, unless a gap or a drain holds it
  always @(negedge clk) begin : drive_in
    logic     nv;
    ialu_in_t nd;
    nv = in_valid;
    nd = in_data;
    if (in_took) begin
      nv      = 1'b0;
      in_took = 1'b0;
    end
    if (!nv && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (op_queue.size() > 0 &&
                   !(op_queue[0].drain && pending_results.size() != 0)) begin
        nd       = op_queue[0].data;
        op_queue.pop_front();
        nv       = 1'b1;
        gap_left = pick_gap();
        sent_cnt++;
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  // Result-side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall  <= 1'b0;
      stall_left = pick_stall();
    end
  end

  // Monitor: predict on input transfer, check on result transfer, watchdog
  always @(posedge clk) begin : monitor
    ialu_out_t exp_r;
    bit        moved;
    moved = 1'b0;
    cycle_cnt++;
    if (rst_n && in_valid && !in_stall) begin
      pending_results.push_back(compute_alu_result(in_data));
      op_count[in_data.func]++;
      if (in_data.func == FUNC_DIV && in_data.operand_b == 0) dz_cnt++;
      in_took = 1'b1;
      moved   = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      moved = 1'b1;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: result %h div_zero %b",
               out_data.result, out_data.div_zero);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.result !== exp_r.result) begin
          $error("result mismatch: expected %h, actual %h", exp_r.result, out_data.result);
          errors++;
        end
        if (out_data.div_zero !== exp_r.div_zero) begin
          $error("div_zero mismatch: expected %b, actual %b",
                 exp_r.div_zero, out_data.div_zero);
          errors++;
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [FUNC_W-1:0] f;
    logic [63:0]       a;
    logic [63:0]       b;
    logic [63:0]       ones;
    ones = {64{1'b1}};

    // Directed: bit ops at both ends of the word
    queue_op(FUNC_SET, 64'd0, 64'd0, 6'd0, 1'b0);
    queue_op(FUNC_SET, 64'd0, ones, 6'd63, 1'b0);
    queue_op(FUNC_SET, ones, 64'd0, 6'd17, 1'b0);
    queue_op(FUNC_CLR, ones, 64'd0, 6'd0, 1'b0);
    queue_op(FUNC_CLR, ones, 64'd0, 6'd63, 1'b0);
    queue_op(FUNC_TGL, 64'd0, 64'd0, 6'd63, 1'b0);
    queue_op(FUNC_TGL, ones, 64'd0, 6'd0, 1'b0);
    queue_op(FUNC_GET, 64'h8000_0000_0000_0000, 64'd0, 6'd63, 1'b0);
    queue_op(FUNC_GET, ones, 64'd0, 6'd0, 1'b0);
    queue_op(FUNC_GET, 64'h7fff_ffff_ffff_fffe, 64'd0, 6'd63, 1'b0);
    // Wrapping add and subtract
    queue_op(FUNC_ADD, ones, 64'd1, 6'd0, 1'b0);
    queue_op(FUNC_ADD, ones, ones, 6'd63, 1'b0);
    queue_op(FUNC_SUB, 64'd0, 64'd1, 6'd0, 1'b0);
    queue_op(FUNC_SUB, ones, ones, 6'd0, 1'b0);
    // Multiply: overflow past the word, zero, all ones
    queue_op(FUNC_MUL, ones, ones, 6'd0, 1'b0);
    queue_op(FUNC_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 6'd0, 1'b0);
    queue_op(FUNC_MUL, 64'd0, ones, 6'd0, 1'b0);
    queue_op(FUNC_MUL, 64'h0000_0000_ffff_ffff, 64'h0000_0000_ffff_ffff, 6'd5, 1'b0);
    // Divide: zero divisor, unit and equal operands, divisor with top bit set
    queue_op(FUNC_DIV, ones, 64'd0, 6'd0, 1'b0);
    queue_op(FUNC_DIV, 64'd0, 64'd0, 6'd0, 1'b0);
    queue_op(FUNC_DIV, ones, 64'd1, 6'd0, 1'b0);
    queue_op(FUNC_DIV, ones, ones, 6'd0, 1'b0);
    queue_op(FUNC_DIV, 64'd5, ones, 6'd0, 1'b0);
    queue_op(FUNC_DIV, ones, 64'h8000_0000_0000_0001, 6'd0, 1'b0);

    // Random mix, with the sender held for a full drain a few times
    for (int n = 0; n < RAND_ITEMS; n++) begin
      f = FUNC_W'($urandom_range(0, 7));
      a = shaped_operand();
      b = shaped_operand();
      if (f == FUNC_DIV) begin
        case ($urandom_range(0, 9))
          0:       b = 64'd0;
          1:       b = 64'($urandom_range(1, 15));
          2:       b = a >> $urandom_range(0, 8);
          default: ;
        endcase
      end
      queue_op(f, a, b, POS_W'($urandom_range(0, 63)),
               (n == 0 || n == 700 || n == 1400));
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Covered %0d transfers: set %0d clr %0d tgl %0d get %0d add %0d sub %0d",
             sent_cnt, op_count[FUNC_SET], op_count[FUNC_CLR], op_count[FUNC_TGL],
             op_count[FUNC_GET], op_count[FUNC_ADD], op_count[FUNC_SUB]);
    $display("  mul %0d div %0d (%0d by zero), random gaps and stalls; %0d mismatches",
             op_count[FUNC_MUL], op_count[FUNC_DIV], dz_cnt, errors);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
